FILE: design/sm64_pkg.sv
// ----------------------------------------------------------------------------
// sm64_pkg
// Shared widths, SplitMix64 constants and the sequencer state type for the
// bounded SplitMix64 generator.
// ----------------------------------------------------------------------------
package sm64_pkg;

    // Data path width of the generator state, the bound and the result.
    localparam int DATA_W = 64;
    localparam int HALF_W = DATA_W / 2;

    // SplitMix64 additive gamma and mixing multipliers.
    localparam logic [DATA_W-1:0] SM_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [DATA_W-1:0] SM_MUL_A = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [DATA_W-1:0] SM_MUL_B = 64'h94D0_49BB_1331_11EB;

    // Xor-shift distances of the mixer.
    localparam int SM_SHIFT_A = 30;
    localparam int SM_SHIFT_B = 27;
    localparam int SM_SHIFT_C = 31;

    // Width of the shared step counter (division runs DATA_W steps).
    localparam int CNT_W = $clog2(DATA_W);

    // Multiplier phases: three partial products and one final accumulate.
    localparam logic [1:0] PH_LO_LO = 2'd0;
    localparam logic [1:0] PH_LO_HI = 2'd1;
    localparam logic [1:0] PH_HI_LO = 2'd2;
    localparam logic [1:0] PH_LAST  = 2'd3;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,   // waiting for a request
        S_CLASS,  // classify the bound, prepare n - 1
        S_ADV,    // advance the state by gamma, first xor-shift
        S_MUL,    // 64x64 low product through the 32x32 multiplier
        S_XS,     // second xor-shift between the two products
        S_FIN,    // final xor-shift, choose the result path
        S_DIV,    // restoring division, one quotient bit per cycle
        S_CHK,    // rejection test on the remainder
        S_DONE    // result held until the output transfer
    } t_fsm;

endpackage

FILE: design/sm64_if.sv
// ----------------------------------------------------------------------------
// sm64 channel interfaces
// Valid/ready channels for requests into and results out of the bounded
// SplitMix64 generator.
// ----------------------------------------------------------------------------

// Request channel: draw mode and bound.
interface sm64_req_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [sm64_pkg::DATA_W-1:0] bound;

    modport source (output valid, output mode, output bound, input ready);
    modport sink   (input valid, input mode, input bound, output ready);
endinterface

// Result channel: one value per request.
interface sm64_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [sm64_pkg::DATA_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

FILE: design/splitmix64_bounded_rng.sv
// ----------------------------------------------------------------------------
// splitmix64_bounded_rng
// SplitMix64 generator with raw draws and unbiased bounded draws by
// rejection, built around one shared 32x32 multiplier and a one-bit-per-cycle
// restoring divider under a small sequencer.
// ----------------------------------------------------------------------------
// The block takes one request at a time and is not ready until its result has
// been transferred. A raw draw advances the state by gamma, then forms two
// 64-bit low products on the shared 32x32 multiplier with an xor-shift step
// after each of them. A bounded draw first classifies the bound; a zero
// bound answers after that step without touching the state, and a
// power-of-two bound follows the raw path with the draw masked to n - 1.
// Any other bound runs a 64-step restoring division of the draw by the bound
// plus one rejection check; a rejected draw repeats the whole draw. Writing
// the seed loads the running state directly and should be done while no
// request is in flight.
module splitmix64_bounded_rng (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [sm64_pkg::DATA_W-1:0] i_cfg_wdata,
    sm64_req_if.sink                    i_req,
    sm64_rsp_if.source                  o_rsp
);
    import sm64_pkg::*;

    t_fsm r_fsm;
    t_fsm n_fsm;

    logic [DATA_W-1:0] r_state;     // running generator state
    logic              r_mode;      // 1 for a bounded draw
    logic [DATA_W-1:0] r_bound;     // n
    logic [DATA_W-1:0] r_nm1;       // n - 1
    logic [DATA_W-1:0] r_z;         // multiplier operand
    logic [DATA_W-1:0] r_prod;      // registered partial product
    logic [DATA_W-1:0] r_acc;       // product accumulator
    logic              r_second;    // second multiplication of the mix
    logic [CNT_W-1:0]  r_cnt;       // multiplier phase or division step
    logic [DATA_W-1:0] r_x;         // mixed draw
    logic [DATA_W-1:0] r_dvd;       // dividend shifting out, msb first
    logic [DATA_W-1:0] r_rem;       // partial remainder
    logic [DATA_W-1:0] r_value;     // result register

    logic [DATA_W-1:0] adv_state;
    logic [DATA_W-1:0] mul_k;
    logic [HALF_W-1:0] mul_a;
    logic [HALF_W-1:0] mul_b;
    logic [1:0]        phase;
    logic [DATA_W-1:0] mix_out;
    logic              is_pow2;
    logic [DATA_W:0]   div_part;
    logic [DATA_W+1:0] div_diff;
    logic              div_borrow;
    logic [DATA_W-1:0] acc_diff;
    logic              draw_ok;

    // Shared arithmetic around the sequencer.
    assign adv_state  = r_state + SM_GAMMA;
    assign phase      = r_cnt[1:0];
    assign mul_k      = r_second ? SM_MUL_B : SM_MUL_A;
    assign mul_a      = (phase == PH_HI_LO) ? r_z[DATA_W-1:HALF_W] : r_z[HALF_W-1:0];
    assign mul_b      = (phase == PH_LO_HI) ? mul_k[DATA_W-1:HALF_W] : mul_k[HALF_W-1:0];
    assign mix_out    = r_acc ^ (r_acc >> SM_SHIFT_C);
    assign is_pow2    = ~|(r_bound & r_nm1);
    assign div_part   = {r_rem, r_dvd[DATA_W-1]};
    assign div_diff   = {1'b0, div_part} - {2'b00, r_bound};
    assign div_borrow = div_diff[DATA_W+1];

    // The draw is kept when x - (x mod n) is at most 2^64 - n, which is the
    // same as x lying below the largest multiple of n that fits in 64 bits.
    assign acc_diff   = r_x - r_rem;
    assign draw_ok    = (acc_diff <= ~r_nm1);

    // Next-state logic of the sequencer.
    always_comb begin
        n_fsm = r_fsm;
        unique case (r_fsm)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_fsm = i_req.mode ? S_CLASS : S_ADV;
                end
            end
            S_CLASS: begin
                n_fsm = (r_bound == '0) ? S_DONE : S_ADV;
            end
            S_ADV: begin
                n_fsm = S_MUL;
            end
            S_MUL: begin
                if (phase == PH_LAST) begin
                    n_fsm = r_second ? S_FIN : S_XS;
                end
            end
            S_XS: begin
                n_fsm = S_MUL;
            end
            S_FIN: begin
                n_fsm = (!r_mode || is_pow2) ? S_DONE : S_DIV;
            end
            S_DIV: begin
                if (r_cnt == CNT_W'(DATA_W - 1)) begin
                    n_fsm = S_CHK;
                end
            end
            S_CHK: begin
                n_fsm = draw_ok ? S_DONE : S_ADV;
            end
            S_DONE: begin
                if (o_rsp.ready) begin
                    n_fsm = S_IDLE;
                end
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

    // Handshake outputs.
    always_comb begin
        i_req.ready = (r_fsm == S_IDLE);
        o_rsp.valid = (r_fsm == S_DONE);
        o_rsp.value = r_value;
    end

    // Sequencer state and generator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm   <= S_IDLE;
            r_state <= '0;
        end else begin
            r_fsm <= n_fsm;
            if (i_cfg_we) begin
                r_state <= i_cfg_wdata;
            end else if (r_fsm == S_ADV) begin
                r_state <= adv_state;
            end
        end
    end

    // Data path registers, stepped by the sequencer.
    always_ff @(posedge i_clk) begin
        unique case (r_fsm)
            S_IDLE: begin
                r_mode  <= i_req.mode;
                r_bound <= i_req.bound;
            end
            S_CLASS: begin
                r_nm1   <= r_bound - DATA_W'(1);
                r_value <= '0;
            end
            S_ADV: begin
                r_z      <= adv_state ^ (adv_state >> SM_SHIFT_A);
                r_second <= 1'b0;
                r_cnt    <= '0;
            end
            S_MUL: begin
                // Low 64 bits of z * k from three 32x32 partial products.
                r_prod <= DATA_W'(mul_a) * DATA_W'(mul_b);
                r_cnt  <= r_cnt + CNT_W'(1);
                if (phase == PH_LO_HI) begin
                    r_acc <= r_prod;
                end else if (phase != PH_LO_LO) begin
                    r_acc[DATA_W-1:HALF_W] <= r_acc[DATA_W-1:HALF_W] + r_prod[HALF_W-1:0];
                end
            end
            S_XS: begin
                r_z      <= r_acc ^ (r_acc >> SM_SHIFT_B);
                r_second <= 1'b1;
                r_cnt    <= '0;
            end
            S_FIN: begin
                r_x   <= mix_out;
                r_dvd <= mix_out;
                r_rem <= '0;
                r_cnt <= '0;
                if (!r_mode) begin
                    r_value <= mix_out;
                end else begin
                    r_value <= mix_out & r_nm1;
                end
            end
            S_DIV: begin
                // One restoring step: bring down the next bit, subtract n.
                r_dvd <= {r_dvd[DATA_W-2:0], 1'b0};
                r_cnt <= r_cnt + CNT_W'(1);
                if (div_borrow) begin
                    r_rem <= div_part[DATA_W-1:0];
                end else begin
                    r_rem <= div_diff[DATA_W-1:0];
                end
            end
            S_CHK: begin
                r_value <= r_rem;
            end
            S_DONE: begin
                r_value <= r_value;
            end
            default: begin
                r_value <= r_value;
            end
        endcase
    end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bounded SplitMix64 generator. Requests go in
// through the request channel, and a predictor that runs in step with the
// block works out each expected value. A checker process compares every
// result transfer with the oldest prediction. The run covers directed
// bound cases and several seeds, then random traffic in three idling phases.
// ----------------------------------------------------------------------------
module testbench;
    import sm64_pkg::*;

    // Draw modes on the request channel.
    localparam logic MODE_RAW     = 1'b0;
    localparam logic MODE_BOUNDED = 1'b1;

    localparam int PHASE_ITEMS  = 234;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 2_000_000;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [DATA_W-1:0] cfg_wdata;

    sm64_req_if req_ch();
    sm64_rsp_if rsp_ch();

    // Percent of cycles in which each side holds off.
    int send_idle_pct;
    int recv_idle_pct;
    int error_count;
    int cycle_count;

    // Generator state as the predictor sees it, and values still owed.
    logic [DATA_W-1:0] model_state;
    logic [DATA_W-1:0] pending_values[$];

    splitmix64_bounded_rng dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // SplitMix64 output mix of one state value.
    function automatic logic [DATA_W-1:0] mix_state(logic [DATA_W-1:0] z);
        z = (z ^ (z >> SM_SHIFT_A)) * SM_MUL_A;
        z = (z ^ (z >> SM_SHIFT_B)) * SM_MUL_B;
        return z ^ (z >> SM_SHIFT_C);
    endfunction

    // One draw: step the state by gamma and mix it.
    function automatic logic [DATA_W-1:0] advance_draw();
        model_state = model_state + SM_GAMMA;
        return mix_state(model_state);
    endfunction

    // Expected value of one request. Non power-of-two bounds reject draws at
    // or above the largest multiple of the bound that fits in 2^64.
    function automatic logic [DATA_W-1:0] predict_value(logic mode,
                                                        logic [DATA_W-1:0] bound);
        logic [DATA_W-1:0] limit;
        logic [DATA_W-1:0] draw;
        if (mode == MODE_RAW)
            return advance_draw();
        if (bound == '0)
            return '0;
        if ((bound & (bound - 1'b1)) == '0)
            return advance_draw() & (bound - 1'b1);
        limit = -((-bound) % bound);
        do
            draw = advance_draw();
        while (draw >= limit);
        return draw % bound;
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // Send one request and record its prediction once the transfer happens.
    task automatic send_request(input logic mode, input logic [DATA_W-1:0] bound);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.mode  <= mode;
        req_ch.bound <= bound;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_values = {pending_values, predict_value(mode, bound)};
    endtask

    // Stop sending and wait until every owed result has been transferred.
    task automatic wait_results_drained();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_values.size() != 0);
    endtask

    // Seed writes happen only with the block idle.
    task automatic load_seed(input logic [DATA_W-1:0] value);
        wait_results_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we      <= 1'b0;
        model_state = value;
    endtask

    // Random request, weighted toward bounds that reach the divider and the
    // rejection loop.
    task automatic send_random_request();
        int                pick;
        logic [DATA_W-1:0] bits;
        pick = $urandom_range(0, 99);
        bits = {$urandom, $urandom};
        if (pick < 20)
            send_request(MODE_RAW, bits);
        else if (pick < 27)
            send_request(MODE_BOUNDED, '0);
        else if (pick < 32)
            send_request(MODE_BOUNDED, DATA_W'(1));
        else if (pick < 44)
            send_request(MODE_BOUNDED, DATA_W'(1) << $urandom_range(0, DATA_W - 1));
        else if (pick < 68)
            send_request(MODE_BOUNDED, DATA_W'($urandom_range(2, 1000)));
        else if (pick < 80)
            send_request(MODE_BOUNDED, {1'b1, bits[DATA_W-2:0]});
        else if (pick < 90)
            send_request(MODE_BOUNDED, bits);
        else
            send_request(MODE_BOUNDED, bits >> $urandom_range(1, DATA_W - 1));
    endtask

    // Raw draws straight out of reset, where the state is zero.
    task automatic test_reset_draws();
        repeat (3) send_request(MODE_RAW, {$urandom, $urandom});
    endtask

    // Zero bound, bound of one, powers of two, odd bounds and rejection.
    task automatic test_bound_cases();
        load_seed(64'h0123_4567_89AB_CDEF);
        send_request(MODE_BOUNDED, '0);
        send_request(MODE_RAW, '1);
        send_request(MODE_BOUNDED, DATA_W'(1));
        send_request(MODE_BOUNDED, DATA_W'(2));
        send_request(MODE_BOUNDED, 64'h8000_0000_0000_0000);
        send_request(MODE_BOUNDED, DATA_W'(3));
        send_request(MODE_BOUNDED, '1);
        // Just above 2^63, about half of all draws are rejected.
        repeat (4) send_request(MODE_BOUNDED, 64'h8000_0000_0000_0001);
        send_request(MODE_BOUNDED, '0);
        send_request(MODE_RAW, '0);
    endtask

    // Seeds at the extremes, including a state that wraps on the first step.
    task automatic test_seed_extremes();
        load_seed('1);
        send_request(MODE_RAW, '0);
        send_request(MODE_BOUNDED, DATA_W'(6));
        load_seed('0);
        send_request(MODE_RAW, '0);
        load_seed(64'h8000_0000_0000_0000);
        send_request(MODE_BOUNDED, DATA_W'(10));
        send_request(MODE_BOUNDED, 64'hFFFF_FFFF_FFFF_FFFE);
    endtask

    // One phase of random traffic under the given idling mix.
    task automatic test_random_phase(input int sender_pct, input int receiver_pct);
        load_seed({$urandom, $urandom});
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        repeat (PHASE_ITEMS) send_random_request();
    endtask

    // Result receiver: ready is redrawn every cycle.
    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Check each result transfer against the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_values.size() == 0) begin
                report_mismatch($sformatf("result %h with no request pending",
                                          rsp_ch.value));
            end else begin
                if (rsp_ch.value !== pending_values[0])
                    report_mismatch($sformatf("value %h, expected %h",
                                              rsp_ch.value, pending_values[0]));
                void'(pending_values.pop_front());
            end
        end
    end

    // Cycle counter with a hard stop.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= '0;
        req_ch.valid <= 1'b0;
        req_ch.mode  <= MODE_RAW;
        req_ch.bound <= '0;
        model_state  = '0;
        send_idle_pct = 12;
        recv_idle_pct = 68;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_draws();
        test_bound_cases();
        test_seed_extremes();
        test_random_phase(12, 68);
        test_random_phase(68, 12);
        test_random_phase(0, 0);

        // Let any stray result show up before the verdict.
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_values.size() != 0)
            report_mismatch("results still owed at end of run");
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
